// ===== hw/rtl/tsmf_pkg.sv =====
`timescale 1ns / 1ps
package tsmf_pkg;

    // fixed widths of the sample path
    localparam int SAMPLE_BITS     = 12;
    localparam int MAX_SAMPLES_DEF = 32;
    // job and write-request fields sized for the largest burst supported
    localparam int CNT_BITS        = 7;
    localparam int ADDR_BITS       = 7;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;
    localparam int SCREEN_BITS     = 12;
    localparam int DIFF_BITS       = 18;
    localparam int PROD_BITS       = 34;
    localparam int FRAC_SHIFT      = 20;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SAMPLE_COUNT = 3'd0,
        REG_MIN_X        = 3'd1,
        REG_MAX_SPREAD   = 3'd2,
        REG_X_OFFSET     = 3'd3,
        REG_X_GAIN       = 3'd4,
        REG_Y_OFFSET     = 3'd5,
        REG_Y_GAIN       = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FEW     = 2'd1,
        ST_XSPREAD = 2'd2,
        ST_YSPREAD = 2'd3
    } t_status;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] raw_x;
        logic [SAMPLE_BITS-1:0] raw_y;
    } t_sample;

    typedef struct packed {
        logic signed [SCREEN_BITS-1:0] screen_x;
        logic signed [SCREEN_BITS-1:0] screen_y;
        t_status                       status;
    } t_result;

    typedef struct packed {
        logic [5:0]         sample_count;
        logic [11:0]        min_x;
        logic [11:0]        max_spread;
        logic [15:0]        x_offset;
        logic signed [15:0] x_gain;
        logic [15:0]        y_offset;
        logic signed [15:0] y_gain;
    } t_cfg;

    // one judged burst handed from front to back
    typedef struct packed {
        logic                bank;
        logic [CNT_BITS-1:0] n;
        logic                too_few;
    } t_job;

    // sample store write request
    typedef struct packed {
        logic                   we;
        logic [ADDR_BITS-1:0]   addr;
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
    } t_wr;

    localparam t_cfg CFG_RESET = '{
        sample_count: 6'd10,
        min_x:        12'd600,
        max_spread:   12'd50,
        x_offset:     16'd5198,
        x_gain:       16'sd4621,
        y_offset:     16'd60160,
        y_gain:       -16'sd6038
    };

endpackage

// ===== hw/rtl/tsmf_front.sv =====
`timescale 1ns / 1ps
module tsmf_front import tsmf_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_accept,
    input  t_sample i_sample,
    output t_wr     o_wr,
    output logic    o_push,
    output t_job    o_job
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);

    logic [CW-1:0] r_recv, n_recv;
    logic [CW-1:0] r_vcnt, n_vcnt;
    logic          r_bank, n_bank;

    logic [6:0]    sc_ext;
    logic [CW-1:0] eff;
    logic          take;
    logic [CW-1:0] vc_next;
    logic [CW-1:0] recv_next;
    logic          done;
    logic [CW:0]   vc_plus2;

    // effective burst length, clamped to the supported range
    always_comb begin
        sc_ext = {1'b0, i_cfg.sample_count};
        if (sc_ext < 7'd3) begin
            eff = CW'(3);
        end else if (sc_ext > 7'(MAX_SAMPLES)) begin
            eff = CW'(MAX_SAMPLES);
        end else begin
            eff = CW'(sc_ext);
        end
    end

    // classify the sample and track the burst
    assign take      = (i_sample.raw_x >= i_cfg.min_x) && (r_vcnt < CW'(MAX_SAMPLES));
    assign vc_next   = r_vcnt + CW'(take);
    assign recv_next = r_recv + CW'(1);
    assign done      = recv_next >= eff;
    assign vc_plus2  = {1'b0, vc_next} + (CW + 1)'(2);

    // store write for a valid sample
    always_comb begin
        o_wr.we   = i_accept && take;
        o_wr.addr = ADDR_BITS'({r_bank, r_vcnt[AW-1:0]});
        o_wr.x    = i_sample.raw_x;
        o_wr.y    = i_sample.raw_y;
    end

    // job for the back end at the end of a burst
    always_comb begin
        o_push        = i_accept && done;
        o_job.bank    = r_bank;
        o_job.n       = CNT_BITS'(vc_next);
        o_job.too_few = (vc_plus2 < {1'b0, eff}) || (vc_next == '0);
    end

    always_comb begin
        n_recv = r_recv;
        n_vcnt = r_vcnt;
        n_bank = r_bank;
        if (i_accept) begin
            if (done) begin
                n_recv = '0;
                n_vcnt = '0;
                n_bank = ~r_bank;
            end else begin
                n_recv = recv_next;
                n_vcnt = vc_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv <= '0;
            r_vcnt <= '0;
            r_bank <= 1'b0;
        end else begin
            r_recv <= n_recv;
            r_vcnt <= n_vcnt;
            r_bank <= n_bank;
        end
    end

endmodule

// ===== hw/rtl/tsmf_queue.sv =====
`timescale 1ns / 1ps
module tsmf_queue import tsmf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    input  logic       i_pop,
    output logic       o_valid,
    output t_job       o_job,
    output logic [1:0] o_count
);

    t_job       r_mem [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign o_count = r_cnt;

    // job entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/tsmf_back.sv =====
`timescale 1ns / 1ps
module tsmf_back import tsmf_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_wr     i_wr,
    input  logic    i_q_valid,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int DEPTH = 2 ** (AW + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_LATCH = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_JUDGE = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    logic [SAMPLE_BITS-1:0] r_xmem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_ymem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rx, r_ry;
    logic [AW:0]            rd_addr;
    logic [AW-1:0]          rd_idx;

    t_state                 r_state;
    logic                   r_bank;
    logic [CW-1:0]          r_n, r_i, r_j, r_lo, r_hi;
    logic [CW-1:0]          r_xl, r_xle, r_yl, r_yle;
    logic [SAMPLE_BITS-1:0] r_cx, r_cy;
    logic [SAMPLE_BITS-1:0] r_xlo, r_xhi, r_ylo, r_yhi;
    t_status                r_status;
    logic signed [DIFF_BITS-1:0] r_dx, r_dy;
    logic signed [PROD_BITS-1:0] r_px, r_py;
    logic                   r_ovalid;
    t_result                r_out;

    logic [CW-1:0]          job_n;
    logic [CW-1:0]          job_hi;
    logic [SAMPLE_BITS:0]   sum_x, sum_y;
    logic [SAMPLE_BITS-1:0] avg_x, avg_y;
    logic [SAMPLE_BITS-1:0] gap_x, gap_y;

    // divide by 2^20 toward zero and clamp to the screen range
    function automatic logic signed [SCREEN_BITS-1:0] scale_sat(
        input logic signed [PROD_BITS-1:0] p
    );
        logic signed [PROD_BITS:0]              biased;
        logic signed [PROD_BITS-FRAC_SHIFT:0]   q;
        biased = {p[PROD_BITS-1], p};
        if (p < 0) begin
            biased = biased + (PROD_BITS + 1)'((1 << FRAC_SHIFT) - 1);
        end
        q = biased[PROD_BITS:FRAC_SHIFT];
        if (q > (PROD_BITS - FRAC_SHIFT + 1)'(2047)) begin
            scale_sat = 12'sd2047;
        end else if (q < -(PROD_BITS - FRAC_SHIFT + 1)'(2048)) begin
            scale_sat = -12'sd2048;
        end else begin
            scale_sat = q[SCREEN_BITS-1:0];
        end
    endfunction

    assign job_n   = CW'(i_job.n);
    assign job_hi  = job_n >> 1;
    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_ovalid;
    assign o_result = r_out;

    assign sum_x = {1'b0, r_xhi} + {1'b0, r_xlo};
    assign sum_y = {1'b0, r_yhi} + {1'b0, r_ylo};
    assign avg_x = sum_x[SAMPLE_BITS:1];
    assign avg_y = sum_y[SAMPLE_BITS:1];
    assign gap_x = r_xhi - r_xlo;
    assign gap_y = r_yhi - r_ylo;

    // store read address
    always_comb begin
        case (r_state)
            S_LOAD:  rd_idx = r_i[AW-1:0];
            S_SCAN:  rd_idx = AW'(r_j + CW'(1));
            default: rd_idx = '0;
        endcase
        rd_addr = {r_bank, rd_idx};
    end

    // sample store, two banks
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_xmem[i_wr.addr[AW:0]] <= i_wr.x;
            r_ymem[i_wr.addr[AW:0]] <= i_wr.y;
        end
        r_rx <= r_xmem[rd_addr];
        r_ry <= r_ymem[rd_addr];
    end

    // selection sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_bank <= i_job.bank;
                        r_n    <= job_n;
                        r_hi   <= job_hi;
                        r_lo   <= (job_hi == '0) ? '0 : job_hi - CW'(1);
                        r_i    <= '0;
                        if (i_job.too_few) begin
                            r_status <= ST_FEW;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= S_LATCH;
                end
                S_LATCH: begin
                    r_cx    <= r_rx;
                    r_cy    <= r_ry;
                    r_j     <= '0;
                    r_xl    <= '0;
                    r_xle   <= '0;
                    r_yl    <= '0;
                    r_yle   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_xl  <= r_xl  + CW'(r_rx <  r_cx);
                    r_xle <= r_xle + CW'(r_rx <= r_cx);
                    r_yl  <= r_yl  + CW'(r_ry <  r_cy);
                    r_yle <= r_yle + CW'(r_ry <= r_cy);
                    if (r_j == r_n - CW'(1)) begin
                        r_state <= S_JUDGE;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                S_JUDGE: begin
                    // candidate holds rank k when less <= k < less-or-equal
                    if (r_xl <= r_lo && r_lo < r_xle) r_xlo <= r_cx;
                    if (r_xl <= r_hi && r_hi < r_xle) r_xhi <= r_cx;
                    if (r_yl <= r_lo && r_lo < r_yle) r_ylo <= r_cy;
                    if (r_yl <= r_hi && r_hi < r_yle) r_yhi <= r_cy;
                    r_i <= r_i + CW'(1);
                    if (r_i == r_n - CW'(1)) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_CHECK: begin
                    r_dx <= $signed({2'b00, avg_x, 4'b0000}) -
                            $signed({2'b00, i_cfg.x_offset});
                    r_dy <= $signed({2'b00, avg_y, 4'b0000}) -
                            $signed({2'b00, i_cfg.y_offset});
                    if (gap_x > i_cfg.max_spread) begin
                        r_status <= ST_XSPREAD;
                        r_state  <= S_OUT;
                    end else if (gap_y > i_cfg.max_spread) begin
                        r_status <= ST_YSPREAD;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_px    <= r_dx * i_cfg.x_gain;
                    r_py    <= r_dy * i_cfg.y_gain;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid      <= 1'b1;
                    r_out.status  <= r_status;
                    if (r_status == ST_OK) begin
                        r_out.screen_x <= scale_sat(r_px);
                        r_out.screen_y <= scale_sat(r_py);
                    end else begin
                        r_out.screen_x <= '0;
                        r_out.screen_y <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |->
            (o_result.screen_x == '0 && o_result.screen_y == '0))
        else $error("rejected burst with nonzero coordinates");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_judge_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JUDGE) |=> (r_state == S_LOAD || r_state == S_CHECK))
        else $error("bad state after candidate judge");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j < r_n))
        else $error("scan index past valid count");
`endif

endmodule

// ===== hw/rtl/touch_sample_median_filter_top.sv =====
`timescale 1ns / 1ps
// after the last sample of a burst, each valid sample is ranked in turn by a scan
//   over the store port (rank scan), then the spread is checked and the result scaled
// throughput: one sample per cycle while fewer than two bursts are waiting or in work
// a burst rejected for too few samples skips the rank scan and goes directly to output
// reset: synchronous active low, counts and queue cleared, registers to defaults
// the result strobe lasts one cycle and cannot be stalled
module touch_sample_median_filter_top import tsmf_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  t_sample                  i_sample,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                     o_valid,
    output t_result                  o_result
);

    t_cfg       r_cfg;
    t_wr        wr;
    t_job       push_job;
    t_job       pop_job;
    logic       push;
    logic       pop;
    logic       q_valid;
    logic [1:0] q_count;
    logic       back_busy;
    logic       accept;

    assign o_cfg_ready = 1'b1;
    // at most two bursts outstanding, one per store bank
    assign busy   = (q_count + {1'b0, back_busy}) >= 2'd2;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SAMPLE_COUNT: r_cfg.sample_count <= i_cfg_data[5:0];
                REG_MIN_X:        r_cfg.min_x        <= i_cfg_data[11:0];
                REG_MAX_SPREAD:   r_cfg.max_spread   <= i_cfg_data[11:0];
                REG_X_OFFSET:     r_cfg.x_offset     <= i_cfg_data;
                REG_X_GAIN:       r_cfg.x_gain       <= $signed(i_cfg_data);
                REG_Y_OFFSET:     r_cfg.y_offset     <= i_cfg_data;
                REG_Y_GAIN:       r_cfg.y_gain       <= $signed(i_cfg_data);
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    tsmf_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_sample (i_sample),
        .o_wr     (wr),
        .o_push   (push),
        .o_job    (push_job)
    );

    tsmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job),
        .o_count (q_count)
    );

    tsmf_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_wr      (wr),
        .i_q_valid (q_valid),
        .i_job     (pop_job),
        .o_pop     (pop),
        .o_busy    (back_busy),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule

// ===== tb/sv/tb_touch_sample_median_filter_top.sv =====
`timescale 1ns / 1ps
module tb_touch_sample_median_filter_top;
    import tsmf_pkg::*;

    localparam int NUM_SLOTS     = 32;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 20000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    t_sample                  i_sample;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     o_valid;
    t_result                  o_result;

    touch_sample_median_filter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    // predictor state: register copy, sample store and counts
    t_cfg         filt_cfg;
    logic [11:0]  x_keep [NUM_SLOTS];
    logic [11:0]  y_keep [NUM_SLOTS];
    int           rx_count;
    int           ok_count;
    t_result      burst_results_q [$];
    int           error_count;
    int           idle_pct;
    int           stall_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int burst_len();
        int eff;
        eff = int'(filt_cfg.sample_count);
        if (eff < 3) eff = 3;
        if (eff > NUM_SLOTS) eff = NUM_SLOTS;
        return eff;
    endfunction

    function automatic logic signed [11:0] calibrate_axis(int avg, logic [15:0] off,
                                                          logic signed [15:0] gain);
        longint d;
        longint q;
        d = longint'(avg) * 16 - longint'(off);
        q = (d * longint'(gain)) / 1048576;
        if (q > 2047) q = 2047;
        if (q < -2048) q = -2048;
        return q[11:0];
    endfunction

    // median of the middle pair; returns spread and floor average
    task automatic middle_pair(input logic [11:0] vals [NUM_SLOTS], input int n,
                               output int spread, output int avg);
        logic [11:0] a [NUM_SLOTS];
        logic [11:0] v;
        int          j;
        int          hi;
        int          lo;
        a = vals;
        for (int i = 1; i < n; i++) begin
            v = a[i];
            j = i;
            while (j > 0 && a[j-1] > v) begin
                a[j] = a[j-1];
                j--;
            end
            a[j] = v;
        end
        hi = n / 2;
        lo = (hi == 0) ? 0 : hi - 1;
        spread = int'(a[hi]) - int'(a[lo]);
        avg = (int'(a[hi]) + int'(a[lo])) / 2;
    endtask

    // model one accepted sample, queue the burst result when it is judged
    task automatic predict_sample(input t_sample s);
        t_result r;
        int      n;
        int      sx;
        int      ax;
        int      sy;
        int      ay;
        if (s.raw_x >= filt_cfg.min_x && ok_count < NUM_SLOTS) begin
            x_keep[ok_count] = s.raw_x;
            y_keep[ok_count] = s.raw_y;
            ok_count++;
        end
        rx_count++;
        if (rx_count < burst_len()) return;
        n = ok_count;
        rx_count = 0;
        ok_count = 0;
        r = '0;
        if (n + 2 < burst_len() || n == 0) begin
            r.status = ST_FEW;
        end else begin
            middle_pair(x_keep, n, sx, ax);
            middle_pair(y_keep, n, sy, ay);
            if (sx > int'(filt_cfg.max_spread)) begin
                r.status = ST_XSPREAD;
            end else if (sy > int'(filt_cfg.max_spread)) begin
                r.status = ST_YSPREAD;
            end else begin
                r.status   = ST_OK;
                r.screen_x = calibrate_axis(ax, filt_cfg.x_offset, filt_cfg.x_gain);
                r.screen_y = calibrate_axis(ay, filt_cfg.y_offset, filt_cfg.y_gain);
            end
        end
        burst_results_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (burst_results_q.size() == 0) begin
                report_mismatch("unexpected result", int'(o_result.status), -1);
            end else begin
                want = burst_results_q.pop_front();
                if (o_result.status != want.status)
                    report_mismatch("status", int'(o_result.status), int'(want.status));
                if (o_result.screen_x != want.screen_x)
                    report_mismatch("screen_x", int'(o_result.screen_x), int'(want.screen_x));
                if (o_result.screen_y != want.screen_y)
                    report_mismatch("screen_y", int'(o_result.screen_y), int'(want.screen_y));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_sample(input int x, input int y);
        t_sample s;
        s.raw_x = x[11:0];
        s.raw_y = y[11:0];
        @(negedge i_clk);
        start    <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (busy);
        predict_sample(s);
        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(5)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        @(negedge i_clk);
        start       <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SAMPLE_COUNT: filt_cfg.sample_count = value[5:0];
            REG_MIN_X:        filt_cfg.min_x        = value[11:0];
            REG_MAX_SPREAD:   filt_cfg.max_spread   = value[11:0];
            REG_X_OFFSET:     filt_cfg.x_offset     = value[15:0];
            REG_X_GAIN:       filt_cfg.x_gain       = value[15:0];
            REG_Y_OFFSET:     filt_cfg.y_offset     = value[15:0];
            REG_Y_GAIN:       filt_cfg.y_gain       = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every burst result is in, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (burst_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_calibration(input int xo, input int xg, input int yo, input int yg);
        write_reg(REG_X_OFFSET, xo);
        write_reg(REG_X_GAIN, xg);
        write_reg(REG_Y_OFFSET, yo);
        write_reg(REG_Y_GAIN, yg);
    endtask

    // burst around a center point, with jitter and some no-touch samples
    task automatic send_burst(input int len, input int cx, input int cy, input int jit,
                              input int noise_pct);
        int x;
        int y;
        for (int i = 0; i < len; i++) begin
            y = cy + $urandom_range(2 * jit) - jit;
            if (y < 0) y = 0;
            if (y > 4095) y = 4095;
            if (filt_cfg.min_x > 0 && $urandom_range(99) < noise_pct) begin
                x = $urandom_range(int'(filt_cfg.min_x) - 1);
            end else begin
                x = cx + $urandom_range(2 * jit) - jit;
                if (x < int'(filt_cfg.min_x)) x = filt_cfg.min_x;
                if (x > 4095) x = 4095;
            end
            send_sample(x, y);
        end
    endtask

    // extremes with reset registers: full-scale touch, then no touch at all
    task automatic test_reset_defaults();
        for (int i = 0; i < 10; i++) send_sample(4095, (i < 5) ? 4095 : 4095);
        for (int i = 0; i < 10; i++) send_sample(0, (i % 2) ? 4095 : 0);
        drain();
    endtask

    // short bursts: spreads, one valid sample, clamped counts, saturation
    task automatic test_burst_cases();
        write_reg(REG_SAMPLE_COUNT, 3);
        write_reg(REG_MAX_SPREAD, 50);
        send_sample(700, 2000); send_sample(800, 2000); send_sample(900, 2000);
        send_sample(1000, 100); send_sample(1000, 300); send_sample(1000, 200);
        send_sample(3000, 1234); send_sample(0, 0); send_sample(599, 4095);
        drain();
        write_reg(REG_SAMPLE_COUNT, 0);
        write_reg(REG_MIN_X, 0);
        write_reg(REG_MAX_SPREAD, 0);
        send_sample(0, 0); send_sample(0, 0); send_sample(0, 0);
        drain();
        write_reg(REG_MAX_SPREAD, 4095);
        set_calibration(0, 32767, 65535, -32768);
        send_sample(4095, 0); send_sample(0, 4095); send_sample(4095, 4095);
        drain();
        set_calibration(65535, -32768, 0, 32767);
        write_reg(REG_SAMPLE_COUNT, 63);
        send_burst(32, 4000, 4000, 90, 0);
        drain();
        write_reg(REG_MIN_X, 4095);
        write_reg(REG_SAMPLE_COUNT, 2);
        send_sample(4095, 17); send_sample(4094, 17); send_sample(4095, 19);
        drain();
    endtask

    // burst length lowered while a burst is partly loaded
    task automatic test_count_lowered();
        write_reg(REG_SAMPLE_COUNT, 10);
        write_reg(REG_MIN_X, 600);
        set_calibration(5198, 4621, 60160, -6038);
        send_burst(6, 2000, 2000, 10, 0);
        drain();
        write_reg(REG_SAMPLE_COUNT, 4);
        send_sample(2001, 1999);
        drain();
    endtask

    task automatic random_registers();
        write_reg(REG_SAMPLE_COUNT, ($urandom_range(9) == 0) ? $urandom_range(63)
                                                             : $urandom_range(3, 12));
        write_reg(REG_MIN_X, ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                      : $urandom_range(1500));
        write_reg(REG_MAX_SPREAD, ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                           : $urandom_range(200));
        set_calibration($urandom_range(65535), $urandom_range(65535),
                        $urandom_range(65535), $urandom_range(65535));
    endtask

    // random bursts in phases of sender idling
    task automatic test_random_bursts();
        int phase_pct [4] = '{0, 53, 29, 0};
        int sent;
        int cx;
        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_pct[p];
            random_registers();
            sent = 0;
            while (sent < 125) begin
                if ($urandom_range(9) == 0) begin
                    send_sample($urandom_range(4095), $urandom_range(4095));
                    sent++;
                end else begin
                    cx = $urandom_range(int'(filt_cfg.min_x), 4095);
                    send_burst(burst_len(), cx, $urandom_range(4095),
                               $urandom_range(40), $urandom_range(3) == 0 ? 40 : 5);
                    sent += burst_len();
                end
            end
            drain();
        end
        idle_pct = 0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_sample     = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        stall_cycles = 0;
        error_count  = 0;
        idle_pct     = 0;
        filt_cfg     = CFG_RESET;
        rx_count     = 0;
        ok_count     = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_burst_cases();
        test_count_lowered();
        test_random_bursts();

        drain();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
